/* rtl/hcbp_pkg.sv */
// ----------------------------------------------------------------------------
// Huffman code bit packer package
// Shared constants, field widths and operation codes for the bit packer.
// ----------------------------------------------------------------------------
`default_nettype none

package hcbp_pkg;

    // Default sizes of the code table.
    localparam int SYMBOL_COUNT_DEF  = 256;
    localparam int MAX_CODE_BITS_DEF = 32;

    // Fixed widths of the beat fields.
    localparam int OP_W       = 2;
    localparam int SYM_W      = 8;
    localparam int CODE_FIELD_W = 32;
    localparam int LEN_W      = 6;
    localparam int BYTE_W     = 8;

    // Bits that can wait between beats (always fewer than one byte).
    localparam int PEND_W     = 3;
    localparam int HOLD_W     = 7;

    // Operation codes carried by the opcode field.
    typedef enum logic [OP_W-1:0] {
        OP_LOAD   = 2'd0,
        OP_ENCODE = 2'd1,
        OP_FLUSH  = 2'd2
    } op_t;

endpackage

`default_nettype wire

/* rtl/huffman_code_bit_packer.sv */
// ----------------------------------------------------------------------------
// Huffman code bit packer
// Looks up per-symbol codes in a loadable table and packs them into bytes.
// ----------------------------------------------------------------------------
// Usage: the input channel (in_valid / in_stall) carries one operation per
// beat: a table load (symbol, code_bits, code_length), a symbol to encode, or
// a flush of the pending bits. The output channel (out_valid / out_stall)
// carries one packed byte per beat, earliest bit in bit 7; last marks the
// final byte produced by one input beat.
// An input beat reads the code RAM at the edge that accepts it and is held
// in the lookup stage; once the output register is free it is packed into
// that register to offer its first byte. One input beat is taken every
// cycle; an encode that completes k bytes holds the output register for k
// output beats (k is at most (code limit + 7) / 8), and the input stalls only
// while a byte-producing beat waits behind that register. Loads and encodes
// that complete no byte never wait on the output.
// Reset clears the code lengths (per-entry valid flags), the pending bits and
// all handshake state; the code RAM itself is not cleared. When out_stall
// is high the offered byte holds, one byte-producing beat more is buffered
// at the lookup stage, and then in_stall rises.
// ----------------------------------------------------------------------------
`default_nettype none

module huffman_code_bit_packer #(
    parameter int SYMBOL_COUNT  = hcbp_pkg::SYMBOL_COUNT_DEF,
    parameter int MAX_CODE_BITS = hcbp_pkg::MAX_CODE_BITS_DEF
) (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    input  wire logic                              in_valid,
    output logic                                   in_stall,
    input  wire logic [hcbp_pkg::OP_W-1:0]         opcode,
    input  wire logic [hcbp_pkg::SYM_W-1:0]        symbol,
    input  wire logic [hcbp_pkg::CODE_FIELD_W-1:0] code_bits,
    input  wire logic [hcbp_pkg::LEN_W-1:0]        code_length,
    output logic                                   out_valid,
    input  wire logic                              out_stall,
    output logic      [hcbp_pkg::BYTE_W-1:0]       out_byte,
    output logic                                   last
);

    import hcbp_pkg::*;

    // Derived sizes.
    localparam int LEN_LIMIT = (MAX_CODE_BITS < CODE_FIELD_W) ? MAX_CODE_BITS
                                                              : CODE_FIELD_W;
    localparam int CODE_W  = LEN_LIMIT;
    localparam int BUF_W   = LEN_LIMIT + HOLD_W;
    localparam int MAX_OUT = BUF_W / BYTE_W;
    localparam int OUT_W   = MAX_OUT * BYTE_W;
    localparam int TOT_W   = $clog2(BUF_W + 1);
    localparam int CNT_W   = $clog2(MAX_OUT + 1);
    localparam int AW      = (SYMBOL_COUNT > 1) ? $clog2(SYMBOL_COUNT) : 1;
    localparam int ENTRY_W = LEN_W + CODE_W;

    // Input handshake.
    logic in_take;
    logic in_range;
    logic [AW-1:0] addr;

    assign in_take  = in_valid && !in_stall;
    assign in_range = ({1'b0, symbol} < (SYM_W + 1)'(SYMBOL_COUNT));
    assign addr     = symbol[AW-1:0];

    // Length saturation and code masking for table loads.
    logic [LEN_W-1:0]   load_len;
    logic [CODE_W-1:0]  load_code;
    logic [ENTRY_W-1:0] load_entry;
    logic               table_we;

    assign load_len   = (code_length > LEN_W'(LEN_LIMIT)) ? LEN_W'(LEN_LIMIT) : code_length;
    assign load_code  = code_bits[CODE_W-1:0] & ~({CODE_W{1'b1}} << load_len);
    assign load_entry = {load_len, load_code};
    assign table_we   = in_take && (opcode == OP_LOAD) && in_range;

    // Code table: length and code side by side, read at acceptance.
    logic [ENTRY_W-1:0] rd_entry;

    hcbp_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (SYMBOL_COUNT),
        .AW    (AW)
    ) u_table (
        .clk   (clk),
        .we    (table_we),
        .waddr (addr),
        .wdata (load_entry),
        .re    (in_take),
        .raddr (addr),
        .rdata (rd_entry)
    );

    // Entry valid flags stand in for the zeroed length store.
    logic [SYMBOL_COUNT-1:0] loaded_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            loaded_reg <= '0;
        end
        else if (table_we)
        begin
            loaded_reg[addr] <= 1'b1;
        end
    end

    // Lookup stage registers.
    logic            s1_valid_reg;
    logic [OP_W-1:0] s1_op_reg;
    logic            s1_hit_reg;
    logic            s1_adv;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else if (in_take)
        begin
            s1_valid_reg <= 1'b1;
        end
        else if (s1_adv)
        begin
            s1_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_take)
        begin
            s1_op_reg  <= opcode;
            s1_hit_reg <= in_range && loaded_reg[addr];
        end
    end

    // Pending bits of an incomplete byte.
    logic [PEND_W-1:0] pend_reg;
    logic [PEND_W-1:0] pend_next;
    logic [HOLD_W-1:0] hold_reg;
    logic [HOLD_W-1:0] hold_next;

    // Packing of the looked-up code onto the pending bits.
    logic [LEN_W-1:0]  enc_len;
    logic [CODE_W-1:0] enc_code;
    logic [BUF_W-1:0]  joined;
    logic [TOT_W-1:0]  total;
    logic [TOT_W-1:0]  nbytes;
    logic [PEND_W-1:0] rem;
    logic [BUF_W-1:0]  aligned;
    logic [2*BYTE_W-2:0] flush_wide;
    logic [BYTE_W-1:0] flush_byte;

    assign enc_len  = s1_hit_reg ? rd_entry[ENTRY_W-1 -: LEN_W] : '0;
    assign enc_code = s1_hit_reg ? rd_entry[CODE_W-1:0] : '0;
    assign joined   = (BUF_W'(hold_reg) << enc_len) | BUF_W'(enc_code);
    assign total    = TOT_W'(pend_reg) + TOT_W'(enc_len);
    assign nbytes   = total >> 3;
    assign rem      = total[PEND_W-1:0];
    assign aligned  = joined << (TOT_W'(BUF_W) - total);

    assign flush_wide = (2*BYTE_W-1)'(hold_reg)
                        << (4'(BYTE_W) - {1'b0, pend_reg});
    assign flush_byte = flush_wide[BYTE_W-1:0];

    // Output register: the bytes of one input beat, drained one per beat.
    logic             out_valid_reg;
    logic [OUT_W-1:0] out_word_reg;
    logic [CNT_W-1:0] out_cnt_reg;
    logic             out_take;
    logic             out_free;
    logic             s1_emits;
    logic             s1_is_enc;
    logic             s1_is_flush;

    assign out_take    = out_valid_reg && !out_stall;
    assign out_free    = !out_valid_reg || (out_take && (out_cnt_reg == CNT_W'(1)));
    assign s1_is_enc   = (s1_op_reg == OP_ENCODE);
    assign s1_is_flush = (s1_op_reg == OP_FLUSH);
    assign s1_emits    = s1_is_flush || (s1_is_enc && (nbytes != '0));
    assign s1_adv      = s1_valid_reg && (out_free || !s1_emits);
    assign in_stall    = s1_valid_reg && !s1_adv;

    // Next pending bits.
    always_comb
    begin
        pend_next = pend_reg;
        hold_next = hold_reg;
        if (s1_adv && s1_is_enc)
        begin
            pend_next = rem;
            hold_next = joined[HOLD_W-1:0] & ~({HOLD_W{1'b1}} << rem);
        end
        else if (s1_adv && s1_is_flush)
        begin
            pend_next = '0;
            hold_next = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pend_reg <= '0;
            hold_reg <= '0;
        end
        else
        begin
            pend_reg <= pend_next;
            hold_reg <= hold_next;
        end
    end

    // Output register control.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
            out_cnt_reg   <= '0;
        end
        else if (s1_adv && s1_emits)
        begin
            out_valid_reg <= 1'b1;
            out_cnt_reg   <= s1_is_flush ? CNT_W'(1) : CNT_W'(nbytes);
        end
        else if (out_take)
        begin
            out_valid_reg <= (out_cnt_reg != CNT_W'(1));
            out_cnt_reg   <= out_cnt_reg - CNT_W'(1);
        end
    end

    // Output byte data, first byte at the top.
    always_ff @(posedge clk)
    begin
        if (s1_adv && s1_emits)
        begin
            if (s1_is_flush)
            begin
                out_word_reg <= OUT_W'(flush_byte) << (OUT_W - BYTE_W);
            end
            else
            begin
                out_word_reg <= aligned[BUF_W-1 -: OUT_W];
            end
        end
        else if (out_take)
        begin
            out_word_reg <= out_word_reg << BYTE_W;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_byte  = out_word_reg[OUT_W-1 -: BYTE_W];
    assign last      = (out_cnt_reg == CNT_W'(1));

endmodule

`default_nettype wire

/* rtl/hcbp_ram.sv */
// ----------------------------------------------------------------------------
// Generic single-port-write RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module hcbp_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic             clk,
    input  wire logic             we,
    input  wire logic [AW-1:0]    waddr,
    input  wire logic [WIDTH-1:0] wdata,
    input  wire logic             re,
    input  wire logic [AW-1:0]    raddr,
    output logic      [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write port.
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // Registered read port.
    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

`default_nettype wire

/* rtl/hcbp_checker.sv */
// ----------------------------------------------------------------------------
// Huffman code bit packer checker
// Port-level assertions on the packer's handshakes, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module hcbp_checker (
    input wire logic       clk,
    input wire logic       rst_n,
    input wire logic       in_stall,
    input wire logic       out_valid,
    input wire logic       out_stall,
    input wire logic [7:0] out_byte,
    input wire logic       last
);

    // The input only waits behind a byte that is on offer.
    a_stall_needs_output: assert property (
        @(posedge clk) disable iff (!rst_n)
        in_stall |-> out_valid
    ) else $error("input stalled with no byte on offer");

    // A beat that is not the last of its group is followed by another byte.
    a_group_continues: assert property (
        @(posedge clk) disable iff (!rst_n)
        (out_valid && !out_stall && !last) |=> out_valid
    ) else $error("byte group ended without a last marker");

    // A stalled output beat holds its byte and marker.
    a_out_hold: assert property (
        @(posedge clk) disable iff (!rst_n)
        (out_valid && out_stall) |=> (out_valid && $stable(out_byte) && $stable(last))
    ) else $error("stalled output beat changed");

endmodule

bind huffman_code_bit_packer hcbp_checker u_hcbp_checker (.*);

`default_nettype wire

/* test/tb_huffman_code_bit_packer.sv */
// ----------------------------------------------------------------------------
// Testbench for the Huffman code bit packer
// Loads code-table entries, encodes symbols and flushes the pending bits,
// first from a directed table and then at random over phases of idling
// and stalling. Every output beat is compared against hand-given bytes or
// a bit-accurate packing predictor kept alongside the block.
// ----------------------------------------------------------------------------

module tb_huffman_code_bit_packer;

    import hcbp_pkg::*;

    localparam int CLK_PERIOD   = 8;
    localparam int CYCLE_LIMIT  = 300000;
    localparam int PHASE_ITEMS  = 112;
    localparam int LONG_HOLD    = 200;
    localparam int TAIL_CYCLES  = 16;
    localparam int NUM_DIRECTED = 25;
    // Longest code the table keeps; longer loads saturate to it.
    localparam int LEN_LIMIT    = (MAX_CODE_BITS_DEF < CODE_FIELD_W) ?
                                  MAX_CODE_BITS_DEF : CODE_FIELD_W;
    // The one opcode value that the block ignores.
    localparam bit [OP_W-1:0] OP_UNUSED = 2'd3;

    // One packed byte as it leaves the block.
    typedef struct packed {
        bit [BYTE_W-1:0] data;
        bit              last;
    } coded_byte_t;

    // One row of the directed table. Where typed is set, the expected bytes
    // are given by hand: t_n bytes, taken from the top of t_word downwards.
    typedef struct packed {
        bit [OP_W-1:0]         op;
        bit [SYM_W-1:0]        sym;
        bit [CODE_FIELD_W-1:0] code;
        bit [LEN_W-1:0]        len;
        bit                    typed;
        bit [2:0]              t_n;
        bit [31:0]             t_word;
    } stim_row_t;

    logic                    clk         = 1'b0;
    logic                    rst_n       = 1'b0;
    logic                    in_valid    = 1'b0;
    logic                    in_stall;
    logic [OP_W-1:0]         opcode      = '0;
    logic [SYM_W-1:0]        symbol      = '0;
    logic [CODE_FIELD_W-1:0] code_bits   = '0;
    logic [LEN_W-1:0]        code_length = '0;
    logic                    out_valid;
    logic                    out_stall   = 1'b0;
    logic [BYTE_W-1:0]       out_byte;
    logic                    last;

    // Predictor state: the code table and the bits waiting to be packed.
    bit [CODE_FIELD_W-1:0] code_tab [SYMBOL_COUNT_DEF];
    bit [LEN_W-1:0]        len_tab  [SYMBOL_COUNT_DEF];
    bit [63:0]             bit_buf;
    int unsigned           bit_cnt;

    coded_byte_t expected_bytes [$];
    coded_byte_t fresh_bytes [$];
    stim_row_t   dir_table [NUM_DIRECTED];

    int  fault_count   = 0;
    int  cycle_count   = 0;
    int  send_idle_pct = 0;
    int  stall_pct     = 0;
    int  hold_left     = 0;
    bit  hold_request  = 1'b0;

    huffman_code_bit_packer dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .opcode      (opcode),
        .symbol      (symbol),
        .code_bits   (code_bits),
        .code_length (code_length),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .out_byte    (out_byte),
        .last        (last)
    );

    always #(CLK_PERIOD / 2) clk = ~clk;

    // Run limit, in case the block stops making progress.
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("Some tests failed");
            $finish;
        end
    end

    // Receiver: a long hold-off when asked for, otherwise random stalls.
    always @(negedge clk)
    begin
        if (hold_request && hold_left == 0)
        begin
            hold_left    = LONG_HOLD;
            hold_request = 1'b0;
        end
        if (hold_left > 0)
        begin
            out_stall <= 1'b1;
            hold_left--;
        end
        else
        begin
            out_stall <= ($urandom_range(0, 99) < stall_pct);
        end
    end

    // Compare every output beat with the oldest expected byte.
    always @(posedge clk)
    begin : check_out
        coded_byte_t want;
        if (out_valid === 1'b1 && out_stall == 1'b0)
        begin
            if (expected_bytes.size() == 0)
            begin
                $error("out_byte beat with nothing expected: out_byte %h, last %b",
                       out_byte, last);
                fault_count++;
            end
            else
            begin
                want = expected_bytes.pop_front();
                if (out_byte !== want.data)
                begin
                    $error("out_byte mismatch: expected %h, actual %h", want.data, out_byte);
                    fault_count++;
                end
                if (last !== want.last)
                begin
                    $error("last mismatch: expected %b, actual %b", want.last, last);
                    fault_count++;
                end
            end
        end
    end

    // Works out the bytes that one accepted beat produces, into fresh_bytes,
    // and moves the packer state on.
    function automatic void predict_packing(bit [OP_W-1:0] op, bit [SYM_W-1:0] sym,
                                            bit [CODE_FIELD_W-1:0] code,
                                            bit [LEN_W-1:0] len);
        int unsigned use_len;
        int unsigned n;
        bit [63:0]   use_code;
        coded_byte_t b;
        fresh_bytes.delete();
        case (op)
            OP_LOAD:
            begin
                if (sym < SYMBOL_COUNT_DEF)
                begin
                    use_len       = (len > LEN_LIMIT) ? LEN_LIMIT : len;
                    len_tab[sym]  = LEN_W'(use_len);
                    code_tab[sym] = CODE_FIELD_W'(code & ((64'd1 << use_len) - 64'd1));
                end
            end
            OP_ENCODE:
            begin
                use_len  = 0;
                use_code = '0;
                if (sym < SYMBOL_COUNT_DEF)
                begin
                    use_len  = len_tab[sym];
                    use_code = code_tab[sym] & ((64'd1 << use_len) - 64'd1);
                end
                bit_buf = (bit_buf << use_len) | use_code;
                bit_cnt += use_len;
                // At most 39 bits can wait, so the loop never needs a cap.
                while (bit_cnt >= 8)
                begin
                    bit_cnt -= 8;
                    b.data  = BYTE_W'(bit_buf >> bit_cnt);
                    b.last  = (bit_cnt < 8);
                    fresh_bytes.push_back(b);
                    bit_buf &= (64'd1 << bit_cnt) - 64'd1;
                end
            end
            OP_FLUSH:
            begin
                n       = bit_cnt & 7;
                b.data  = BYTE_W'(bit_buf << (8 - n));
                b.last  = 1'b1;
                fresh_bytes.push_back(b);
                bit_buf = '0;
                bit_cnt = 0;
            end
            default:
            begin
            end
        endcase
    endfunction

    // Offers one input beat, waits for it to be taken, and records the bytes
    // it should produce. Called and left at a falling edge.
    task automatic offer_item(bit [OP_W-1:0] op, bit [SYM_W-1:0] sym,
                              bit [CODE_FIELD_W-1:0] code, bit [LEN_W-1:0] len,
                              bit typed, bit [2:0] t_n, bit [31:0] t_word);
        coded_byte_t b;
        while ($urandom_range(0, 99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        in_valid    <= 1'b1;
        opcode      <= op;
        symbol      <= sym;
        code_bits   <= code;
        code_length <= len;
        do
            @(posedge clk);
        while (in_stall !== 1'b0);
        predict_packing(op, sym, code, len);
        if (typed)
        begin
            for (int k = 0; k < t_n; k++)
            begin
                b.data = t_word[31 - 8 * k -: 8];
                b.last = (k == t_n - 1);
                expected_bytes.push_back(b);
            end
        end
        else
        begin
            foreach (fresh_bytes[k])
                expected_bytes.push_back(fresh_bytes[k]);
        end
        @(negedge clk);
    endtask

    // Sender pause: nothing is offered until every expected byte has come.
    task automatic wait_drained();
        in_valid <= 1'b0;
        while (expected_bytes.size() != 0)
            @(posedge clk);
        @(negedge clk);
    endtask

    initial
    begin : stimulus
        bit [OP_W-1:0]         op;
        bit [SYM_W-1:0]        sym;
        bit [CODE_FIELD_W-1:0] code;
        bit [LEN_W-1:0]        len;
        int                    r;

        foreach (len_tab[i])
        begin
            len_tab[i]  = '0;
            code_tab[i] = '0;
        end
        bit_buf = '0;
        bit_cnt = 0;

        // Directed rows: empty flush, unloaded symbol, unused opcode, the
        // longest and overlong codes, dropped high code bits, zero length.
        dir_table = '{
            '{OP_FLUSH,  8'h00, 32'h0000_0000, 6'd0,  1'b1, 3'd1, 32'h0000_0000},
            '{OP_ENCODE, 8'h00, 32'h0000_0000, 6'd0,  1'b1, 3'd0, 32'h0000_0000},
            '{OP_UNUSED, 8'hFF, 32'hFFFF_FFFF, 6'd63, 1'b1, 3'd0, 32'h0000_0000},
            '{OP_LOAD,   8'hFF, 32'hFFFF_FFFF, 6'd32, 1'b1, 3'd0, 32'h0000_0000},
            '{OP_ENCODE, 8'hFF, 32'h0000_0000, 6'd0,  1'b1, 3'd4, 32'hFFFF_FFFF},
            '{OP_LOAD,   8'h00, 32'h0000_0000, 6'd0,  1'b1, 3'd0, 32'h0000_0000},
            '{OP_ENCODE, 8'h00, 32'h0000_0000, 6'd0,  1'b1, 3'd0, 32'h0000_0000},
            '{OP_LOAD,   8'h01, 32'hFFFF_FFFF, 6'd63, 1'b1, 3'd0, 32'h0000_0000},
            '{OP_ENCODE, 8'h01, 32'h0000_0000, 6'd0,  1'b1, 3'd4, 32'hFFFF_FFFF},
            '{OP_LOAD,   8'h02, 32'hFFFF_FFFF, 6'd3,  1'b1, 3'd0, 32'h0000_0000},
            '{OP_ENCODE, 8'h02, 32'h0000_0000, 6'd0,  1'b1, 3'd0, 32'h0000_0000},
            '{OP_FLUSH,  8'h00, 32'h0000_0000, 6'd0,  1'b1, 3'd1, 32'hE000_0000},
            '{OP_LOAD,   8'h80, 32'h0000_0005, 6'd3,  1'b0, 3'd0, 32'h0000_0000},
            '{OP_ENCODE, 8'h80, 32'h0000_0000, 6'd0,  1'b0, 3'd0, 32'h0000_0000},
            '{OP_ENCODE, 8'hFF, 32'h0000_0000, 6'd0,  1'b0, 3'd0, 32'h0000_0000},
            '{OP_ENCODE, 8'h80, 32'h0000_0000, 6'd0,  1'b0, 3'd0, 32'h0000_0000},
            '{OP_ENCODE, 8'h80, 32'h0000_0000, 6'd0,  1'b0, 3'd0, 32'h0000_0000},
            '{OP_LOAD,   8'h55, 32'hAAAA_5555, 6'd33, 1'b0, 3'd0, 32'h0000_0000},
            '{OP_ENCODE, 8'h55, 32'h0000_0000, 6'd0,  1'b0, 3'd0, 32'h0000_0000},
            '{OP_FLUSH,  8'h00, 32'h0000_0000, 6'd0,  1'b0, 3'd0, 32'h0000_0000},
            '{OP_FLUSH,  8'h00, 32'h0000_0000, 6'd0,  1'b1, 3'd1, 32'h0000_0000},
            '{OP_LOAD,   8'h7F, 32'h0000_00A5, 6'd8,  1'b0, 3'd0, 32'h0000_0000},
            '{OP_ENCODE, 8'h7F, 32'h0000_0000, 6'd0,  1'b1, 3'd1, 32'hA500_0000},
            '{OP_LOAD,   8'h01, 32'h0000_0000, 6'd0,  1'b0, 3'd0, 32'h0000_0000},
            '{OP_ENCODE, 8'h01, 32'h0000_0000, 6'd0,  1'b1, 3'd0, 32'h0000_0000}
        };

        // Hold reset, then release it at a falling edge.
        repeat (2) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        for (int i = 0; i < NUM_DIRECTED; i++)
            offer_item(dir_table[i].op, dir_table[i].sym, dir_table[i].code,
                       dir_table[i].len, dir_table[i].typed, dir_table[i].t_n,
                       dir_table[i].t_word);
        wait_drained();

        // Random phases: no idling, idle sender, stalling receiver, both light.
        for (int phase = 0; phase < 4; phase++)
        begin
            case (phase)
                0: begin send_idle_pct = 0;  stall_pct = 0;  end
                1: begin send_idle_pct = 81; stall_pct = 0;  end
                2: begin send_idle_pct = 0;  stall_pct = 81; end
                default: begin send_idle_pct = 6; stall_pct = 6; end
            endcase
            for (int k = 0; k < PHASE_ITEMS; k++)
            begin
                // Part way into the busy phase the receiver holds off for a
                // long stretch so that the block fills and stalls its input.
                // The sender drops valid while it asks for the hold-off, so that the beat
                // just taken is not offered a second time.
                if (phase == 0 && k == 40)
                begin
                    in_valid <= 1'b0;
                    @(posedge clk);
                    hold_request = 1'b1;
                    @(negedge clk);
                end
                // Symbols mostly from a small set, so that encodes find loaded
                // entries; now and then from the whole range.
                sym = ($urandom_range(0, 3) == 0) ? SYM_W'($urandom_range(0, 255)) :
                                                    SYM_W'($urandom_range(0, 15));
                r = $urandom_range(0, 99);
                if (r < 25)
                    op = OP_LOAD;
                else if (r < 92)
                    op = OP_ENCODE;
                else if (r < 98)
                    op = OP_FLUSH;
                else
                    op = OP_UNUSED;
                code = $urandom;
                r = $urandom_range(0, 99);
                if (r < 5)
                    len = '0;
                else if (r < 75)
                    len = LEN_W'($urandom_range(1, 12));
                else if (r < 90)
                    len = LEN_W'($urandom_range(13, 32));
                else
                    len = LEN_W'($urandom_range(33, 63));
                offer_item(op, sym, code, len, 1'b0, 3'd0, 32'h0);
            end
            wait_drained();
        end

        repeat (TAIL_CYCLES) @(posedge clk);
        if (fault_count == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule
